// File: hdl/box_blur_3x3_edge_clipped_macros.svh
// Assertion macros used by the box blur queue.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BB_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hdl/bbb_pkg.sv
// Types, constants and helpers for the 3x3 box blur.
`timescale 1ns / 1ps
package bbb_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int FW_W    = 11;
	localparam int FH_W    = 13;
	localparam int PIX_W   = 24;
	localparam int SUM_W   = 12;
	localparam int RCP_W   = 17;
	localparam int RCP_SH  = 16;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_t;

	// One averaging job: nine window pixels, which of them count, frame end flag.
	typedef struct packed {
		logic [8:0][PIX_W-1:0] px;
		logic [8:0]            mask;
		logic                  frame_end;
	} job_t;

	// Ceiling of 2^16 / n for the neighbor counts that can occur.
	function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd6:    r = 17'd10923;
			4'd9:    r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// File: hdl/bbb_queue.sv
// Two-entry job queue between the front and back sections.
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_clipped_macros.svh"
module bbb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbb_pkg::job_t push_job,
	input  logic          pop,
	output bbb_pkg::job_t head,
	output logic          full,
	output logic          empty
);
	import bbb_pkg::*;

	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_q];

	// Store a pushed job.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`BB_NEVER(a_no_push_full, push && full, "job pushed into full queue")
	`BB_NEVER(a_no_pop_empty, pop && empty, "job popped from empty queue")
	`BB_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count out of range")
	`BB_ASSERT(a_cnt_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "count did not rise")
endmodule

// File: hdl/bbb_front.sv
// Front section: accepts items, keeps line stores and window, issues jobs.
`timescale 1ns / 1ps
module bbb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [12:0]   cfg_data,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  bbb_pkg::in_t  pix,
	output logic          push,
	output bbb_pkg::job_t push_job,
	input  logic          q_full
);
	import bbb_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_UPD  = 4'd2;
	localparam logic [3:0] S_J1   = 4'd3;
	localparam logic [3:0] S_J2   = 4'd4;
	localparam logic [3:0] S_D1   = 4'd5;
	localparam logic [3:0] S_D2   = 4'd6;
	localparam logic [3:0] S_D3   = 4'd7;
	localparam logic [3:0] S_D4   = 4'd8;
	localparam logic [3:0] S_DJ   = 4'd9;

	logic [3:0]       state_q;
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] drain_q;
	logic             draining_q;
	logic [COL_W-1:0] c_q;
	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] k_q;
	logic [PIX_W-1:0] pix_q;
	logic             two_q;
	logic [COL_W-1:0] addr_q;
	logic [PIX_W-1:0] rd_a_q;
	logic [PIX_W-1:0] rd_b_q;
	logic [2:0][2:0][PIX_W-1:0] win_q;
	logic [PIX_W-1:0] mem_a [MAX_WIDTH];
	logic [PIX_W-1:0] mem_b [MAX_WIDTH];

	logic [FW_W-1:0]  w;
	logic [FH_W-1:0]  h;
	logic [COL_W-1:0] c_n;
	logic [ROW_W-1:0] r_n;
	logic [COL_W-1:0] k_n;
	logic             accept;
	logic             c_last;
	logic             k_last;
	logic [2:0]       rowv;
	logic [2:0]       colv;

	// Clamp the configured frame size.
	always_comb begin
		if (fw_q == '0) begin
			w = FW_W'(1);
		end else if (fw_q > FW_W'(MAX_WIDTH)) begin
			w = FW_W'(MAX_WIDTH);
		end else begin
			w = fw_q;
		end
		if (fh_q == '0) begin
			h = FH_W'(1);
		end else if ({1'b0, fh_q} > (FH_W + 1)'(MAX_HEIGHT)) begin
			h = FH_W'(MAX_HEIGHT);
		end else begin
			h = fh_q;
		end
	end

	assign pix_stall = (state_q != S_IDLE);
	assign accept    = pix_valid && !pix_stall;
	assign c_n = (FW_W'(col_q) < w) ? col_q : '0;
	assign r_n = (FH_W'(row_q) < h) ? row_q : '0;
	assign k_n = (FW_W'(drain_q) < w) ? drain_q : COL_W'(w - FW_W'(1));
	assign c_last = (FW_W'(c_q) + FW_W'(1) == w);
	assign k_last = (FW_W'(k_q) + FW_W'(1) == w);

	// Build the job for the current output position.
	always_comb begin
		rowv = 3'b000;
		colv = 3'b000;
		push = 1'b0;
		push_job.frame_end = 1'b0;
		unique case (state_q)
			S_J1: begin
				rowv = {1'b1, 1'b1, (r_q >= ROW_W'(2))};
				colv = {1'b1, 1'b1, (c_q >= COL_W'(2))};
				push = !q_full;
			end
			S_J2: begin
				rowv = {1'b1, 1'b1, (r_q >= ROW_W'(2))};
				colv = {1'b1, (c_q >= COL_W'(1)), 1'b0};
				push = !q_full;
			end
			S_DJ: begin
				rowv = {1'b0, 1'b1, (h >= FH_W'(2))};
				colv = {!k_last, 1'b1, (k_q >= COL_W'(1))};
				push = !q_full;
				push_job.frame_end = k_last;
			end
			default: begin
				push = 1'b0;
			end
		endcase
		for (int i = 0; i < 9; i++) begin
			push_job.px[i]   = win_q[i / 3][i % 3];
			push_job.mask[i] = rowv[i / 3] & colv[i % 3];
		end
	end

	// Line stores: write back on the update step, read every cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			mem_a[c_q] <= rd_b_q;
			mem_b[c_q] <= pix_q;
		end
		rd_a_q <= mem_a[addr_q];
		rd_b_q <= mem_b[addr_q];
	end

	// Sequence each item and keep frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fw_q       <= FW_W'(640);
			fh_q       <= FH_W'(480);
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
			win_q      <= '0;
			c_q        <= '0;
			r_q        <= '0;
			k_q        <= '0;
			pix_q      <= '0;
			two_q      <= 1'b0;
			addr_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				REG_HEIGHT: fh_q <= cfg_data;
				default:    fw_q <= fw_q;
			endcase
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && pix.func == FUNC_PIXEL && !draining_q) begin
						c_q     <= c_n;
						r_q     <= r_n;
						addr_q  <= c_n;
						pix_q   <= {pix.red_in, pix.green_in, pix.blue_in};
						state_q <= S_RD;
					end else if (accept && pix.func == FUNC_DRAIN && draining_q) begin
						k_q     <= k_n;
						addr_q  <= k_n - COL_W'(1);
						state_q <= S_D1;
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k][0] <= win_q[k][1];
						win_q[k][1] <= win_q[k][2];
					end
					win_q[0][2] <= rd_a_q;
					win_q[1][2] <= rd_b_q;
					win_q[2][2] <= pix_q;
					two_q <= (r_q >= ROW_W'(1)) && c_last;
					if (c_last) begin
						col_q <= '0;
						if (FH_W'(r_q) + FH_W'(1) == h) begin
							draining_q <= 1'b1;
							drain_q    <= '0;
							row_q      <= r_q;
						end else begin
							row_q <= r_q + ROW_W'(1);
						end
					end else begin
						col_q <= c_q + COL_W'(1);
						row_q <= r_q;
					end
					if (r_q >= ROW_W'(1) && c_q >= COL_W'(1)) begin
						state_q <= S_J1;
					end else if (r_q >= ROW_W'(1) && c_last) begin
						state_q <= S_J2;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_J1: begin
					if (!q_full) begin
						state_q <= two_q ? S_J2 : S_IDLE;
					end
				end
				S_J2: begin
					if (!q_full) begin
						state_q <= S_IDLE;
					end
				end
				S_D1: begin
					addr_q  <= k_q;
					state_q <= S_D2;
				end
				S_D2: begin
					win_q[0][0] <= rd_a_q;
					win_q[1][0] <= rd_b_q;
					addr_q      <= k_q + COL_W'(1);
					state_q     <= S_D3;
				end
				S_D3: begin
					win_q[0][1] <= rd_a_q;
					win_q[1][1] <= rd_b_q;
					state_q     <= S_D4;
				end
				S_D4: begin
					win_q[0][2] <= rd_a_q;
					win_q[1][2] <= rd_b_q;
					state_q     <= S_DJ;
				end
				S_DJ: begin
					if (!q_full) begin
						if (k_last) begin
							draining_q <= 1'b0;
							drain_q    <= '0;
							col_q      <= '0;
							row_q      <= '0;
						end else begin
							drain_q <= k_q + COL_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: hdl/bbb_back.sv
// Back section: sums masked window pixels and divides by the neighbor count.
`timescale 1ns / 1ps
module bbb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bbb_pkg::job_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output bbb_pkg::out_t res
);
	import bbb_pkg::*;

	logic             en;
	logic             s1_v;
	logic [SUM_W-1:0] sr_s1, sg_s1, sb_s1;
	logic [3:0]       n_s1;
	logic             fe_s1;
	logic             out_v_q;
	out_t             out_q;
	logic [SUM_W-1:0] sr, sg, sb;
	logic [3:0]       n;
	logic [RCP_W-1:0] rcp;
	logic [SUM_W+RCP_W-1:0] pr, pg, pb;

	assign en        = !out_v_q || !res_stall;
	assign pop       = en && !q_empty;
	assign res_valid = out_v_q;
	assign res       = out_q;

	// Add the counted neighbors of the queue head.
	always_comb begin
		sr = '0;
		sg = '0;
		sb = '0;
		for (int i = 0; i < 9; i++) begin
			if (head.mask[i]) begin
				sr = sr + SUM_W'(head.px[i][23:16]);
				sg = sg + SUM_W'(head.px[i][15:8]);
				sb = sb + SUM_W'(head.px[i][7:0]);
			end
		end
		n = 4'($countones(head.mask));
	end

	// Round half up and divide through the reciprocal.
	always_comb begin
		rcp = recip(n_s1);
		pr = (sr_s1 + SUM_W'(n_s1 >> 1)) * rcp;
		pg = (sg_s1 + SUM_W'(n_s1 >> 1)) * rcp;
		pb = (sb_s1 + SUM_W'(n_s1 >> 1)) * rcp;
	end

	// Advance both stages when the output can move.
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1 <= sr;
			sg_s1 <= sg;
			sb_s1 <= sb;
			n_s1  <= n;
			fe_s1 <= head.frame_end;
			out_q.red_out   <= pr[RCP_SH +: 8];
			out_q.green_out <= pg[RCP_SH +: 8];
			out_q.blue_out  <= pb[RCP_SH +: 8];
			out_q.frame_end <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			s1_v    <= !q_empty;
			out_v_q <= s1_v;
		end
	end
endmodule

// File: hdl/box_blur_3x3_edge_clipped.sv
// Top level of the edge-clipped 3x3 RGB box blur.
`timescale 1ns / 1ps
// Usage:
// Input beats (pix_valid / pix_stall) carry raster-order pixels (func 0) or
// drain ticks (func 1). Each pixel beat past the first row and column
// releases the blurred pixel one row up and one column left, plus the last
// one of that row at the end of a row. After the last frame row, one drain
// beat per column releases the final row; frame_end marks the last result.
// Result beats (res_valid / res_stall) leave in raster order through a
// two-entry job queue and a two-stage divide pipeline.
// The front section takes no new beat before it has issued the jobs of the
// last: pixels pass the read, update and job states, drains S_D1 to S_DJ.
// Configuration writes (cfg_we, cfg_index, cfg_data) set width and height and
// restart the frame; write only while idle.
// Reset: 640 x 480, counters and window cleared; line stores are not cleared.
// A stalled receiver holds the result; the queue fills, then input stalls.
module box_blur_3x3_edge_clipped (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [12:0]   cfg_data,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  bbb_pkg::in_t  pix,
	output logic          res_valid,
	input  logic          res_stall,
	output bbb_pkg::out_t res
);
	import bbb_pkg::*;

	logic push;
	job_t push_job;
	job_t head;
	logic pop;
	logic q_full;
	logic q_empty;

	bbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	bbb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);
endmodule
